>>> rtl/yuyv_pkg.sv
// Shared types and constants of the YUYV to RGB stream converter.
// Used by the front end, the command queue, the color back end and the top level.
`default_nettype none

package yuyv_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_STRIDE = 16384;

  // Longest source row that can occur after the stride is raised to twice the width.
  localparam int MAX_ROW = (MAX_STRIDE > 2 * MAX_WIDTH) ? MAX_STRIDE : 2 * MAX_WIDTH;

  // Register field widths.
  localparam int FW_W = 13;
  localparam int FH_W = 13;
  localparam int FS_W = 15;

  // Derived internal widths.
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int RB_W  = W_W + 1;
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = H_W;
  localparam int ST_W  = $clog2(MAX_ROW + 1);
  localparam int COL_W = $clog2(MAX_ROW);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 2'd2;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [FS_W-1:0] ROW_STRIDE_RESET   = 15'd0;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  // Position of a byte inside a Y0 U Y1 V group.
  localparam logic [1:0] LANE_Y0 = 2'd0;
  localparam logic [1:0] LANE_U  = 2'd1;
  localparam logic [1:0] LANE_Y1 = 2'd2;
  localparam logic [1:0] LANE_V  = 2'd3;

  typedef enum logic [1:0] {
    CMD_PAIR,
    CMD_BLACK,
    CMD_ERROR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] y0;
    logic [7:0] u;
    logic [7:0] y1;
    logic [7:0] v;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic       err;
  } pixel_t;

endpackage

`default_nettype wire

>>> rtl/yuyv_front.sv
// Front end: holds configuration and frame position, classifies each source byte
// and issues pixel commands to the queue. Depends on yuyv_pkg.
`default_nettype none

module yuyv_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [yuyv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [yuyv_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire [7:0]                     in_byte_i,
  input  wire                           in_end_i,
  input  wire                           q_full_i,
  output logic                          push_o,
  output yuyv_pkg::cmd_t                push_data_o
);
  import yuyv_pkg::*;

  logic [FW_W-1:0]  fw_q;
  logic [FH_W-1:0]  fh_q;
  logic [FS_W-1:0]  fs_q;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [7:0]       y0_q, y0_d, u_q, u_d, y1_q, y1_d;
  logic             done_q, done_d;

  logic [W_W-1:0]   w_eff;
  logic [H_W-1:0]   h_eff;
  logic [RB_W-1:0]  row_bytes, pair_bytes;
  logic [ST_W-1:0]  s_lim, s_eff, col_x, col_next;
  logic             accept, final_row, row_done, complete;
  logic             emit;
  cmd_t             cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RESET;
      fh_q <= FRAME_HEIGHT_RESET;
      fs_q <= ROW_STRIDE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_wdata_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_wdata_i[FH_W-1:0];
        CFG_ROW_STRIDE:   fs_q <= cfg_wdata_i[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry after the range limits are applied.
  always_comb begin
    if (fw_q == '0) w_eff = W_W'(1);
    else if (int'(fw_q) > MAX_WIDTH) w_eff = W_W'(MAX_WIDTH);
    else w_eff = W_W'(fw_q);

    if (fh_q == '0) h_eff = H_W'(1);
    else if (int'(fh_q) > MAX_HEIGHT) h_eff = H_W'(MAX_HEIGHT);
    else h_eff = H_W'(fh_q);

    row_bytes  = {w_eff, 1'b0};
    pair_bytes = {w_eff[W_W-1:1], 2'b00};

    if (int'(fs_q) > MAX_STRIDE) s_lim = ST_W'(MAX_STRIDE);
    else s_lim = ST_W'(fs_q);
    s_eff = (s_lim < ST_W'(row_bytes)) ? ST_W'(row_bytes) : s_lim;
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    y0_d   = y0_q;
    u_d    = u_q;
    y1_d   = y1_q;
    emit   = 1'b0;
    cmd    = '{kind: CMD_PAIR, y0: y0_q, u: u_q, y1: y1_q, v: in_byte_i, last: 1'b0};

    col_x     = ST_W'(col_q);
    col_next  = col_x + ST_W'(1);
    final_row = (H_W'(row_q) == h_eff - H_W'(1));
    row_done  = (col_x == ST_W'(row_bytes) - ST_W'(1));

    // A row index at or past the height, as after a height change, ends the frame.
    complete = done_q || (H_W'(row_q) >= h_eff);

    if (!complete) begin
      if (col_x < ST_W'(pair_bytes)) begin
        case (col_q[1:0])
          LANE_Y0: y0_d = in_byte_i;
          LANE_U:  u_d  = in_byte_i;
          LANE_Y1: y1_d = in_byte_i;
          LANE_V: begin
            emit     = 1'b1;
            cmd.last = final_row && row_done;
          end
          default: ;
        endcase
      end else if (row_done) begin
        // Unpaired last pixel of an odd-width row goes out black.
        emit     = 1'b1;
        cmd.kind = CMD_BLACK;
        cmd.last = final_row;
      end

      if (final_row && row_done) begin
        complete = 1'b1;
      end else if (col_next >= s_eff) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
        if (H_W'(row_d) >= h_eff) complete = 1'b1;
      end else begin
        col_d = col_next[COL_W-1:0];
      end
    end

    if (in_end_i) begin
      if (!complete) begin
        emit     = 1'b1;
        cmd.kind = CMD_ERROR;
        cmd.last = 1'b0;
      end
      col_d    = '0;
      row_d    = '0;
      y0_d     = '0;
      u_d      = '0;
      y1_d     = '0;
      complete = 1'b0;
    end
    done_d = complete;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      y0_q   <= '0;
      u_q    <= '0;
      y1_q   <= '0;
      done_q <= 1'b0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      y0_q   <= y0_d;
      u_q    <= u_d;
      y1_q   <= y1_d;
      done_q <= done_d;
    end
  end

  assign push_o      = accept && emit;
  assign push_data_o = cmd;

endmodule

`default_nettype wire

>>> rtl/yuyv_queue.sv
// Short command FIFO that decouples the byte front end from the color back end.
// Depends on yuyv_pkg.
`default_nettype none

module yuyv_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  yuyv_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            valid_o,
  output yuyv_pkg::cmd_t  data_o
);
  import yuyv_pkg::*;

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QP_W:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (QP_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (int'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + QP_W'(1);
    if (do_pop)  rd_d = (int'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + QP_W'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + (QP_W+1)'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - (QP_W+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> rtl/yuyv_back.sv
// Color back end: constant-coefficient products in one stage, then sums, rounding
// and clamping into a two-pixel output buffer. Depends on yuyv_pkg.
`default_nettype none

module yuyv_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cmd_valid_i,
  input  yuyv_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output yuyv_pkg::pixel_t out_pixel_o
);
  import yuyv_pkg::*;

  localparam int PW = 20;

  function automatic logic [7:0] round_sat(input logic signed [PW-1:0] t);
    logic signed [PW-1:0] r;
    r = t + PW'(128);
    if (r[PW-1]) return 8'd0;
    if (|r[PW-2:16]) return 8'd255;
    return r[15:8];
  endfunction

  // Product stage.
  logic                 p_valid_q;
  cmd_kind_e            p_kind_q;
  logic                 p_last_q;
  logic signed [PW-1:0] p_c0_q, p_c1_q, p_er_q, p_du_q, p_eg_q, p_db_q;

  logic signed [9:0]    c0, c1, d, e;
  logic                 load_p, adv_p, out_xfer;

  // Output buffer: up to two pixels, oldest in slot zero.
  pixel_t               o_pix0_q, o_pix1_q, n_pix0, n_pix1;
  logic [1:0]           o_cnt_q;

  assign out_xfer = out_valid_o && out_ready_i;
  assign adv_p    = p_valid_q && ((o_cnt_q == 2'd0) || ((o_cnt_q == 2'd1) && out_ready_i));
  assign load_p   = cmd_valid_i && (!p_valid_q || adv_p);
  assign cmd_pop_o = load_p;

  assign c0 = $signed({2'b00, cmd_i.y0}) - 10'sd16;
  assign c1 = $signed({2'b00, cmd_i.y1}) - 10'sd16;
  assign d  = $signed({2'b00, cmd_i.u}) - 10'sd128;
  assign e  = $signed({2'b00, cmd_i.v}) - 10'sd128;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (load_p) begin
      p_valid_q <= 1'b1;
    end else if (adv_p) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_p) begin
      p_kind_q <= cmd_i.kind;
      p_last_q <= cmd_i.last;
      p_c0_q   <= PW'(c0) * 20'sd298;
      p_c1_q   <= PW'(c1) * 20'sd298;
      p_er_q   <= PW'(e) * 20'sd409;
      p_du_q   <= PW'(d) * 20'sd100;
      p_eg_q   <= PW'(e) * 20'sd208;
      p_db_q   <= PW'(d) * 20'sd516;
    end
  end

  always_comb begin
    n_pix0 = '0;
    n_pix1 = '0;
    case (p_kind_q)
      CMD_PAIR: begin
        n_pix0.red   = round_sat(p_c0_q + p_er_q);
        n_pix0.green = round_sat(p_c0_q - p_du_q - p_eg_q);
        n_pix0.blue  = round_sat(p_c0_q + p_db_q);
        n_pix1.red   = round_sat(p_c1_q + p_er_q);
        n_pix1.green = round_sat(p_c1_q - p_du_q - p_eg_q);
        n_pix1.blue  = round_sat(p_c1_q + p_db_q);
        n_pix1.last  = p_last_q;
      end
      CMD_BLACK: n_pix0.last = p_last_q;
      CMD_ERROR: n_pix0.err  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_cnt_q <= 2'd0;
    end else if (adv_p) begin
      o_cnt_q <= (p_kind_q == CMD_PAIR) ? 2'd2 : 2'd1;
    end else if (out_xfer) begin
      o_cnt_q <= o_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_p) begin
      o_pix0_q <= n_pix0;
      o_pix1_q <= n_pix1;
    end else if (out_xfer) begin
      o_pix0_q <= o_pix1_q;
    end
  end

  assign out_valid_o = (o_cnt_q != 2'd0);
  assign out_pixel_o = o_pix0_q;

endmodule

`default_nettype wire

>>> rtl/yuyv_to_rgb_stream_converter.sv
// Top level of the YUYV to RGB stream converter (BT.601 limited range).
// Instantiates yuyv_front, yuyv_queue and yuyv_back; depends on yuyv_pkg.
//
// Usage:
//   The slave stream takes one source byte per transfer (tdata) with tlast
//   marking the last byte of the supplied buffer. The master stream gives one
//   RGB pixel per transfer: tdata holds red, green, blue; tlast is set on the
//   final pixel of the frame; tuser flags a buffer that ended before the frame
//   was complete (that transfer carries black and tlast low).
//   Geometry is set through the write port (width, height, stride) while idle.
//   Throughput: one byte per cycle on input while the command queue is not full
//   and one pixel per cycle on output while the receiver is ready; every V byte
//   produces two pixels, so with the receiver ready a byte-per-cycle stream
//   never backs up. A byte's pixels appear once its command has passed the
//   command queue, product stage and output buffer; the second pixel follows.
//   When the receiver stalls, the four-entry command queue keeps taking bytes
//   until it fills, then tready drops; nothing is lost or repeated.
//   Reset clears the frame position, the held bytes and all queues, and loads
//   width 640, height 480 and stride 0.
`default_nettype none

module yuyv_to_rgb_stream_converter (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [yuyv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [yuyv_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire [7:0]                      s_axis_tdata_i,  // [7:0] data_byte
  input  wire                            s_axis_tlast_i,  // buffer_end
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  output logic [23:0]                    m_axis_tdata_o,  // [7:0] red, [15:8] green, [23:16] blue
  output logic                           m_axis_tlast_o,  // last_pixel
  output logic                           m_axis_tuser_o   // frame_error
);
  import yuyv_pkg::*;

  logic   q_full, push, q_valid, pop;
  cmd_t   push_data, q_data;
  pixel_t pix;

  yuyv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_end_i    (s_axis_tlast_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  yuyv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  yuyv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_data),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_pixel_o (pix)
  );

  assign m_axis_tdata_o = {pix.blue, pix.green, pix.red};
  assign m_axis_tlast_o = pix.last;
  assign m_axis_tuser_o = pix.err;

endmodule

`default_nettype wire
